// ----- hdl/signal_mask_and_delivery_unit_assert.svh -----
// Assertion macros shared by the signal unit.
`ifndef SIGNAL_MASK_AND_DELIVERY_UNIT_ASSERT_SVH
`define SIGNAL_MASK_AND_DELIVERY_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SMDU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SMDU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/smdu_pkg.sv -----
package smdu_pkg;

	typedef enum logic [2:0] {
		FN_QUEUE    = 3'd0,
		FN_CONSUME  = 3'd1,
		FN_SETACT   = 3'd2,
		FN_PROCMASK = 3'd3,
		FN_SUSPEND  = 3'd4,
		FN_READPEND = 3'd5,
		FN_DELIVER  = 3'd6,
		FN_RETURN   = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		HOW_BLOCK   = 2'd0,
		HOW_UNBLOCK = 2'd1,
		HOW_SET     = 2'd2
	} how_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVAL   = 2'd1,
		ST_INTR    = 2'd2,
		ST_NO_DEST = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OC_NONE    = 2'd0,
		OC_DISCARD = 2'd1,
		OC_TERM    = 2'd2,
		OC_HANDLER = 2'd3
	} outcome_t;

	localparam logic [63:0] UNMASKABLE      = (64'd1 << 8) | (64'd1 << 18);
	localparam logic [63:0] DEFAULT_NONTERM = 64'h0000_0000_087F_0000;
	localparam logic [6:0]  SIG_KILL        = 7'd9;
	localparam logic [6:0]  SIG_STOP        = 7'd19;
	localparam logic [7:0]  SET_BYTES       = 8'd8;
	localparam logic [7:0]  EXIT_BASE       = 8'd128;
	localparam logic [63:0] HANDLER_DFL     = 64'd0;
	localparam logic [63:0] HANDLER_IGN     = 64'd1;

	localparam int FL_INFO      = 0;
	localparam int FL_NODEFER   = 1;
	localparam int FL_RESETHAND = 2;

	typedef struct packed {
		func_t       func;
		logic [6:0]  sig_number;
		logic [7:0]  set_size;
		logic [1:0]  how;
		logic        value_present;
		logic [63:0] mask_value;
		logic [63:0] new_handler;
		logic [63:0] new_restorer;
		logic [2:0]  new_flags;
		logic [63:0] new_handler_mask;
	} req_t;

	typedef struct packed {
		status_t     status;
		outcome_t    outcome;
		logic [6:0]  chosen_signal;
		logic [7:0]  term_code;
		logic [63:0] handler_address;
		logic [63:0] restorer_address;
		logic [2:0]  action_flags_out;
		logic [63:0] mask_out;
	} rsp_t;

	typedef struct packed {
		logic [63:0] handler;
		logic [63:0] restorer;
		logic [2:0]  flags;
		logic [63:0] mask;
	} action_t;

	function automatic logic [63:0] clean_mask(logic [63:0] m, logic [63:0] valid_set);
		return m & valid_set & ~UNMASKABLE;
	endfunction

endpackage

// ----- hdl/smdu_if.sv -----
interface smdu_req_if;
	logic          valid;
	logic          ready;
	smdu_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface smdu_rsp_if;
	logic          valid;
	logic          ready;
	smdu_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/signal_mask_and_delivery_unit.sv -----
// A request transaction is accepted, then executed; execute waits while an earlier response is unclaimed.
// No new request is taken until execute ends; the action table read issued at accept
//   is registered, and the read-modify-write completes in the execute cycle.
// A finished response sits in an output register while the next request is taken.
// Reset (arst_n low, async): pending, blocked and saved sets cleared, all actions read
//   as default through per-entry valid bits; usable on the first cycle after release.
module signal_mask_and_delivery_unit #(
	parameter int NUM_SIGNALS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	smdu_req_if.sink    req,
	smdu_rsp_if.source  rsp
);

	`include "signal_mask_and_delivery_unit_assert.svh"

	localparam int          IDX_W     = $clog2(NUM_SIGNALS);
	localparam logic [63:0] VALID_SET = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - NUM_SIGNALS);
	// bits the blocked set may never hold
	localparam logic [63:0] BLK_NEVER = smdu_pkg::UNMASKABLE | ~VALID_SET;

	// architectural state
	logic [63:0] pending_q, blocked_q, saved_mask_q;
	logic        saved_valid_q;

	// control
	logic busy_q, out_valid_q;
	smdu_pkg::rsp_t rsp_q;

	// captured request
	smdu_pkg::req_t    req_s1;
	logic [IDX_W-1:0]  addr_s1;
	logic              found_s1;

	logic              in_acc, exec_fire;
	logic              pick_found;
	logic [IDX_W-1:0]  pick_idx, rd_addr;
	logic [6:0]        sig_m1;
	smdu_pkg::action_t rd_act, wr_act;
	logic              wr_en;

	logic [63:0]       pending_d, blocked_d, saved_mask_d;
	logic              saved_valid_d;
	smdu_pkg::rsp_t    rsp_d;

	assign in_acc    = req.valid && req.ready;
	// execute waits only if the previous response is still unclaimed
	assign exec_fire = busy_q && (!out_valid_q || rsp.ready);

	assign req.ready = !busy_q;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = rsp_q;

	// lowest pending-and-unblocked signal, from the settled state
	smdu_pick #(
		.NUM_SIGNALS(NUM_SIGNALS),
		.IDX_W      (IDX_W)
	) u_pick (
		.ready_set(pending_q[NUM_SIGNALS-1:0] & ~blocked_q[NUM_SIGNALS-1:0]),
		.found    (pick_found),
		.idx      (pick_idx)
	);

	assign sig_m1  = req.data.sig_number - 7'd1;
	assign rd_addr = (req.data.func == smdu_pkg::FN_DELIVER) ? pick_idx : sig_m1[IDX_W-1:0];

	smdu_action_mem #(
		.NUM_SIGNALS(NUM_SIGNALS),
		.IDX_W      (IDX_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_acc),
		.rd_addr(rd_addr),
		.rd_data(rd_act),
		.wr_en  (wr_en),
		.wr_addr(addr_s1),
		.wr_data(wr_act)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1   <= req.data;
			addr_s1  <= rd_addr;
			found_s1 <= pick_found;
		end
		if (exec_fire) begin
			rsp_q <= rsp_d;
		end
	end

	// execute: one read-modify-write of the table plus the set registers
	always_comb begin
		logic        sig_ok, size_ok;
		logic [63:0] sel_bit, nb;
		logic [6:0]  chosen;
		logic        wr_req;

		sig_ok  = (req_s1.sig_number >= 7'd1) && (req_s1.sig_number <= 7'(NUM_SIGNALS));
		size_ok = (req_s1.set_size == smdu_pkg::SET_BYTES);
		sel_bit = 64'd1 << addr_s1;
		chosen  = 7'(addr_s1) + 7'd1;
		nb      = '0;
		wr_req  = 1'b0;
		wr_act  = rd_act;

		pending_d     = pending_q;
		blocked_d     = blocked_q;
		saved_mask_d  = saved_mask_q;
		saved_valid_d = saved_valid_q;
		rsp_d         = '0;

		case (req_s1.func)
			smdu_pkg::FN_QUEUE: begin
				if (sig_ok) begin
					pending_d = pending_q | sel_bit;
				end
			end
			smdu_pkg::FN_CONSUME: begin
				if (sig_ok) begin
					pending_d = pending_q & ~sel_bit;
				end
			end
			smdu_pkg::FN_SETACT: begin
				if (!size_ok || !sig_ok || req_s1.sig_number == smdu_pkg::SIG_KILL
						|| req_s1.sig_number == smdu_pkg::SIG_STOP) begin
					rsp_d.status = smdu_pkg::ST_INVAL;
				end else begin
					rsp_d.handler_address  = rd_act.handler;
					rsp_d.restorer_address = rd_act.restorer;
					rsp_d.action_flags_out = rd_act.flags;
					rsp_d.mask_out         = rd_act.mask;
					if (req_s1.value_present) begin
						wr_req          = 1'b1;
						wr_act.handler  = req_s1.new_handler;
						wr_act.restorer = req_s1.new_restorer;
						wr_act.flags    = req_s1.new_flags;
						wr_act.mask     = req_s1.new_handler_mask;
					end
				end
			end
			smdu_pkg::FN_PROCMASK: begin
				if (!size_ok) begin
					rsp_d.status = smdu_pkg::ST_INVAL;
				end else begin
					rsp_d.mask_out = blocked_q;
					if (req_s1.value_present) begin
						case (req_s1.how)
							smdu_pkg::HOW_BLOCK:   nb = blocked_q | req_s1.mask_value;
							smdu_pkg::HOW_UNBLOCK: nb = blocked_q & ~req_s1.mask_value;
							smdu_pkg::HOW_SET:     nb = req_s1.mask_value;
							default: begin
								nb           = blocked_q;
								rsp_d.status = smdu_pkg::ST_INVAL;
							end
						endcase
						blocked_d = smdu_pkg::clean_mask(nb, VALID_SET);
					end
				end
			end
			smdu_pkg::FN_SUSPEND: begin
				if (!size_ok) begin
					rsp_d.status = smdu_pkg::ST_INVAL;
				end else begin
					rsp_d.status = smdu_pkg::ST_INTR;
					if (req_s1.value_present) begin
						nb = smdu_pkg::clean_mask(req_s1.mask_value, VALID_SET);
						// keep the temporary mask only if it lets something through
						if ((pending_q & ~nb) != 64'd0) begin
							blocked_d     = nb;
							saved_mask_d  = blocked_q;
							saved_valid_d = 1'b1;
						end
					end
				end
			end
			smdu_pkg::FN_READPEND: begin
				if (!size_ok) begin
					rsp_d.status = smdu_pkg::ST_INVAL;
				end else if (!req_s1.value_present) begin
					rsp_d.status = smdu_pkg::ST_NO_DEST;
				end else begin
					rsp_d.mask_out = pending_q & blocked_q;
				end
			end
			smdu_pkg::FN_DELIVER: begin
				if (found_s1) begin
					rsp_d.chosen_signal = chosen;
					pending_d           = pending_q & ~sel_bit;
					if (rd_act.handler == smdu_pkg::HANDLER_IGN) begin
						rsp_d.outcome = smdu_pkg::OC_DISCARD;
					end else if (rd_act.handler == smdu_pkg::HANDLER_DFL) begin
						if (smdu_pkg::DEFAULT_NONTERM[addr_s1]) begin
							rsp_d.outcome = smdu_pkg::OC_DISCARD;
						end else begin
							rsp_d.outcome   = smdu_pkg::OC_TERM;
							rsp_d.term_code = smdu_pkg::EXIT_BASE + {1'b0, chosen};
						end
					end else begin
						rsp_d.outcome          = smdu_pkg::OC_HANDLER;
						rsp_d.handler_address  = rd_act.handler;
						rsp_d.restorer_address = rd_act.restorer;
						rsp_d.action_flags_out = rd_act.flags;
						// frame mask: suspend's saved set wins over the live one
						if (saved_valid_q) begin
							rsp_d.mask_out = saved_mask_q;
							saved_valid_d  = 1'b0;
						end else begin
							rsp_d.mask_out = blocked_q;
						end
						nb = blocked_q;
						if (!rd_act.flags[smdu_pkg::FL_NODEFER]) begin
							nb = nb | sel_bit;
						end
						blocked_d = smdu_pkg::clean_mask(nb | rd_act.mask, VALID_SET);
						// one-shot handler reverts to default
						if (rd_act.flags[smdu_pkg::FL_RESETHAND]) begin
							wr_req                             = 1'b1;
							wr_act.handler                     = smdu_pkg::HANDLER_DFL;
							wr_act.flags[smdu_pkg::FL_INFO]    = 1'b0;
						end
					end
				end
			end
			smdu_pkg::FN_RETURN: begin
				blocked_d = smdu_pkg::clean_mask(req_s1.mask_value, VALID_SET);
			end
			default: begin
				rsp_d = '0;
			end
		endcase

		wr_en = exec_fire && wr_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			pending_q     <= '0;
			blocked_q     <= '0;
			saved_mask_q  <= '0;
			saved_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (exec_fire) begin
				busy_q <= 1'b0;
			end
			if (exec_fire) begin
				out_valid_q   <= 1'b1;
				pending_q     <= pending_d;
				blocked_q     <= blocked_d;
				saved_mask_q  <= saved_mask_d;
				saved_valid_q <= saved_valid_d;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`SMDU_ASSERT_NXT(a_accept_busy, in_acc, busy_q, "accepted request did not enter execute")
	`SMDU_ASSERT_NXT(a_exec_result, exec_fire, out_valid_q && !busy_q, "execute left no response")
	`SMDU_ASSERT_NOW(a_wr_in_exec, wr_en, busy_q && !in_acc, "table write outside execute")
	`SMDU_ASSERT_NOW(a_pend_range, 1'b1, (pending_q & ~VALID_SET) == 64'd0, "pending bit out of range")
	`SMDU_ASSERT_NOW(a_blk_clean, 1'b1, (blocked_q & BLK_NEVER) == 64'd0, "unblockable bit set")

endmodule

// ----- hdl/smdu_action_mem.sv -----
module smdu_action_mem #(
	parameter int NUM_SIGNALS = 64,
	parameter int IDX_W       = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [IDX_W-1:0]      rd_addr,
	output smdu_pkg::action_t     rd_data,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_addr,
	input  smdu_pkg::action_t     wr_data
);

	smdu_pkg::action_t       mem [NUM_SIGNALS];
	logic [NUM_SIGNALS-1:0]  valid_q;
	smdu_pkg::action_t       rd_data_q;
	logic                    rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// never-written entries read as the cleared action
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

// ----- hdl/smdu_pick.sv -----
module smdu_pick #(
	parameter int NUM_SIGNALS = 64,
	parameter int IDX_W       = 6
) (
	input  logic [NUM_SIGNALS-1:0] ready_set,
	output logic                   found,
	output logic [IDX_W-1:0]       idx
);

	logic [NUM_SIGNALS-1:0] lowest;

	// isolate lowest set bit, then encode the one-hot
	assign lowest = ready_set & (~ready_set + NUM_SIGNALS'(1));
	assign found  = |ready_set;

	always_comb begin
		idx = '0;
		for (int i = 0; i < NUM_SIGNALS; i++) begin
			if (lowest[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
	end

endmodule

// ----- dv/tb.sv -----
module tb;

	import smdu_pkg::*;

	localparam int NSIG = 64;
	// Signal bits that may ever be blocked: within range, never those of signals 9 or 19.
	localparam logic [63:0] SIG_BITS  = {64{1'b1}} >> (64 - NSIG);
	localparam logic [63:0] BLOCKABLE = SIG_BITS & ~UNMASKABLE;
	localparam logic [63:0] ONES      = {64{1'b1}};
	localparam logic [63:0] A5        = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam rsp_t        RS_ZERO   = '0;
	localparam int          N_RANDOM  = 750;
	localparam int          QUIET_MAX = 1000;  // cycles with no transaction on either side

	logic clk = 1'b0;
	logic arst_n;

	smdu_req_if req_if();
	smdu_rsp_if rsp_if();

	signal_mask_and_delivery_unit #(
		.NUM_SIGNALS(NSIG)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the unit's state, advanced once per accepted request.
	logic [63:0] pend_bits;
	logic [63:0] blk_bits;
	logic [63:0] susp_mask;
	logic        susp_held;
	logic [63:0] act_handler [64];
	logic [63:0] act_restorer[64];
	logic [2:0]  act_flags   [64];
	logic [63:0] act_hmask   [64];

	// Responses still owed by the unit, oldest first.
	rsp_t owed[$];

	// Directed stimulus: a request, and optionally the response read straight off the spec.
	typedef struct {
		req_t q;
		bit   typed;
		rsp_t want;
	} dir_row_t;
	dir_row_t dir_rows[$];

	// Per-transaction expectation override, driven alongside the request payload
	// so that it lines up with the accept edge.
	bit   typed_on;
	rsp_t typed_rsp;

	bit src_idle_on;
	bit snk_stall_on;
	int n_sent;
	int n_bad;
	int quiet;
	int next_drain;

	function automatic req_t req_of(func_t fn, logic [6:0] sg, logic [7:0] sz, logic [1:0] hw,
			logic pv, logic [63:0] mv, logic [63:0] nh, logic [63:0] nr, logic [2:0] nf,
			logic [63:0] nm);
		req_t q;
		q.func             = fn;
		q.sig_number       = sg;
		q.set_size         = sz;
		q.how              = hw;
		q.value_present    = pv;
		q.mask_value       = mv;
		q.new_handler      = nh;
		q.new_restorer     = nr;
		q.new_flags        = nf;
		q.new_handler_mask = nm;
		return q;
	endfunction

	function automatic rsp_t rsp_of(status_t st, outcome_t oc, logic [6:0] ch, logic [7:0] ec,
			logic [63:0] h, logic [63:0] r, logic [2:0] f, logic [63:0] m);
		rsp_t o;
		o.status           = st;
		o.outcome          = oc;
		o.chosen_signal    = ch;
		o.term_code        = ec;
		o.handler_address  = h;
		o.restorer_address = r;
		o.action_flags_out = f;
		o.mask_out         = m;
		return o;
	endfunction

	function void add_row(req_t q, bit typed, rsp_t want);
		dir_row_t row;
		row.q     = q;
		row.typed = typed;
		row.want  = want;
		dir_rows.push_back(row);
	endfunction

	// Set values that exercise the masks: empty, full, dense, sparse, one-hot.
	function automatic logic [63:0] any_mask();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return ONES;
			2: return {$urandom, $urandom};
			5: return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
		endcase
	endfunction

	// Fully random request, mostly well-formed so it gets past argument checks.
	function automatic req_t noise_req();
		logic [6:0]  sg;
		logic [7:0]  sz;
		logic [1:0]  hw;
		logic [63:0] nh;
		sg = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 64));
		sz = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : SET_BYTES;
		hw = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		case ($urandom_range(0, 3))
			0: nh = HANDLER_DFL;
			1: nh = HANDLER_IGN;
			default: nh = {$urandom, $urandom};
		endcase
		return req_of(func_t'($urandom_range(0, 7)), sg, sz, hw, $urandom_range(0, 7) != 0,
			any_mask(), nh, {$urandom, $urandom}, 3'($urandom_range(0, 7)), any_mask());
	endfunction

	// Applies one request to the shadow state and returns the response it must produce.
	function automatic rsp_t signal_op_result(req_t q);
		rsp_t        o;
		logic [5:0]  ix;
		logic        in_range;
		logic        size_ok;
		logic [63:0] old_blk;
		logic [63:0] ready_set;
		logic [2:0]  f;
		int          b;
		o         = RS_ZERO;
		ix        = 6'(q.sig_number - 7'd1);
		in_range  = (q.sig_number >= 7'd1) && (q.sig_number <= 7'(NSIG));
		size_ok   = (q.set_size == SET_BYTES);
		case (q.func)
			FN_QUEUE: begin
				if (in_range) pend_bits[ix] = 1'b1;
			end
			FN_CONSUME: begin
				if (in_range) pend_bits[ix] = 1'b0;
			end
			FN_SETACT: begin
				if (!size_ok || !in_range || q.sig_number == SIG_KILL
						|| q.sig_number == SIG_STOP) begin
					o.status = ST_INVAL;
				end else begin
					o.handler_address  = act_handler[ix];
					o.restorer_address = act_restorer[ix];
					o.action_flags_out = act_flags[ix];
					o.mask_out         = act_hmask[ix];
					if (q.value_present) begin
						act_handler[ix]  = q.new_handler;
						act_restorer[ix] = q.new_restorer;
						act_flags[ix]    = q.new_flags;
						act_hmask[ix]    = q.new_handler_mask;
					end
				end
			end
			FN_PROCMASK: begin
				if (!size_ok) begin
					o.status = ST_INVAL;
				end else begin
					o.mask_out = blk_bits;
					if (q.value_present) begin
						case (q.how)
							HOW_BLOCK:   blk_bits = blk_bits | q.mask_value;
							HOW_UNBLOCK: blk_bits = blk_bits & ~q.mask_value;
							HOW_SET:     blk_bits = q.mask_value;
							default:     o.status = ST_INVAL;
						endcase
						blk_bits = blk_bits & BLOCKABLE;
					end
				end
			end
			FN_SUSPEND: begin
				if (!size_ok) begin
					o.status = ST_INVAL;
				end else begin
					// Temporary mask sticks only if it lets something through.
					if (q.value_present) begin
						old_blk  = blk_bits;
						blk_bits = q.mask_value & BLOCKABLE;
						if ((pend_bits & ~blk_bits) == '0) begin
							blk_bits = old_blk;
						end else begin
							susp_mask = old_blk;
							susp_held = 1'b1;
						end
					end
					o.status = ST_INTR;
				end
			end
			FN_READPEND: begin
				if (!size_ok)
					o.status = ST_INVAL;
				else if (!q.value_present)
					o.status = ST_NO_DEST;
				else
					o.mask_out = pend_bits & blk_bits;
			end
			FN_DELIVER: begin
				ready_set = pend_bits & ~blk_bits;
				if (ready_set != '0) begin
					b = 0;
					while (!ready_set[b]) b++;
					o.chosen_signal = 7'(b + 1);
					pend_bits[b]    = 1'b0;
					if (act_handler[b] == HANDLER_IGN) begin
						o.outcome = OC_DISCARD;
					end else if (act_handler[b] == HANDLER_DFL) begin
						if (DEFAULT_NONTERM[b]) begin
							o.outcome = OC_DISCARD;
						end else begin
							o.outcome   = OC_TERM;
							o.term_code = EXIT_BASE + 8'(b + 1);
						end
					end else begin
						f                  = act_flags[b];
						o.outcome          = OC_HANDLER;
						o.handler_address  = act_handler[b];
						o.restorer_address = act_restorer[b];
						o.action_flags_out = f;
						// Frame mask: the mask saved by suspend wins, once.
						if (susp_held) begin
							o.mask_out = susp_mask;
							susp_held  = 1'b0;
						end else begin
							o.mask_out = blk_bits;
						end
						if (!f[FL_NODEFER]) blk_bits[b] = 1'b1;
						blk_bits = (blk_bits | act_hmask[b]) & BLOCKABLE;
						if (f[FL_RESETHAND]) begin
							act_handler[b] = HANDLER_DFL;
							act_flags[b]   = f & ~(3'd1 << FL_INFO);
						end
					end
				end
			end
			default: begin
				// Return from handler: restore caller's mask unconditionally.
				blk_bits = q.mask_value & BLOCKABLE;
			end
		endcase
		return o;
	endfunction

	function automatic int field_bad(string nm, logic [63:0] e, logic [63:0] a);
		if (a !== e) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, nm, e, a);
			return 1;
		end
		return 0;
	endfunction

	// Response check first, then the request accepted on the same edge.
	rsp_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (owed.size() == 0) begin
					$display("%0t: unexpected response, expected none, actual %h",
						$time, rsp_if.data);
					n_bad++;
				end else begin
					want = owed.pop_front();
					n_bad += field_bad("status", 64'(want.status), 64'(rsp_if.data.status));
					n_bad += field_bad("outcome", 64'(want.outcome), 64'(rsp_if.data.outcome));
					n_bad += field_bad("chosen_signal", 64'(want.chosen_signal),
						64'(rsp_if.data.chosen_signal));
					n_bad += field_bad("term_code", 64'(want.term_code),
						64'(rsp_if.data.term_code));
					n_bad += field_bad("handler_address", want.handler_address,
						rsp_if.data.handler_address);
					n_bad += field_bad("restorer_address", want.restorer_address,
						rsp_if.data.restorer_address);
					n_bad += field_bad("action_flags_out", 64'(want.action_flags_out),
						64'(rsp_if.data.action_flags_out));
					n_bad += field_bad("mask_out", want.mask_out, rsp_if.data.mask_out);
				end
			end
			if (req_if.valid && req_if.ready) begin
				// Shadow state always advances; typed rows replace the computed answer.
				want = signal_op_result(req_if.data);
				owed.push_back(typed_on ? typed_rsp : want);
			end
		end
	end

	// Watchdog: a stuck handshake on either side ends the run.
	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_MAX) begin
				$display("%0t: no transaction for %0d cycles", $time, quiet);
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	// Response side back-pressure: random stall bursts.
	initial begin
		int stall;
		stall = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall == 0 && snk_stall_on && $urandom_range(0, 7) == 0)
				stall = $urandom_range(1, 19);
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				stall--;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// Offers one request, possibly after an idle burst, and returns on its accept edge.
	task automatic put_txn(req_t q, bit typed, rsp_t rs);
		if (src_idle_on && $urandom_range(0, 4) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= q;
		typed_on     <= typed;
		typed_rsp    <= rs;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		n_sent++;
	endtask

	// Drops valid and waits until every owed response has come back.
	task automatic drain_owed();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (owed.size() != 0) @(posedge clk);
	endtask

	initial begin
		int          s;
		int          n_total;
		logic [63:0] nh;
		arst_n        = 1'b0;
		req_if.valid <= 1'b0;
		req_if.data  <= '0;
		typed_on     <= 1'b0;
		typed_rsp    <= RS_ZERO;
		src_idle_on   = 1'b1;
		snk_stall_on  = 1'b1;
		n_sent        = 0;
		n_bad         = 0;
		quiet         = 0;
		next_drain    = 0;
		pend_bits     = '0;
		blk_bits      = '0;
		susp_mask     = '0;
		susp_held     = 1'b0;
		for (int i = 0; i < 64; i++) begin
			act_handler[i]  = '0;
			act_restorer[i] = '0;
			act_flags[i]    = '0;
			act_hmask[i]    = '0;
		end

		// Directed part: empty state, range edges, refused arguments, the three
		// delivery outcomes and the unblockable signals.
		add_row(req_of(FN_READPEND, 7'd1, SET_BYTES, HOW_BLOCK, 1'b1, ONES, '0, '0, '0, '0),
			1, RS_ZERO);
		add_row(req_of(FN_READPEND, 7'd1, SET_BYTES, HOW_BLOCK, 1'b0, '0, '0, '0, '0, '0),
			1, rsp_of(ST_NO_DEST, OC_NONE, '0, '0, '0, '0, '0, '0));
		add_row(req_of(FN_READPEND, 7'd1, 8'd7, HOW_BLOCK, 1'b1, '0, '0, '0, '0, '0),
			1, rsp_of(ST_INVAL, OC_NONE, '0, '0, '0, '0, '0, '0));
		// nothing pending: empty delivery
		add_row(req_of(FN_DELIVER, 7'd0, '0, HOW_BLOCK, 1'b0, '0, '0, '0, '0, '0), 1, RS_ZERO);
		// out-of-range queue is dropped silently
		add_row(req_of(FN_QUEUE, 7'd0, SET_BYTES, HOW_BLOCK, 1'b1, '0, '0, '0, '0, '0),
			1, RS_ZERO);
		add_row(req_of(FN_QUEUE, 7'd64, SET_BYTES, HOW_BLOCK, 1'b1, '0, '0, '0, '0, '0),
			1, RS_ZERO);
		add_row(req_of(FN_CONSUME, 7'd64, SET_BYTES, HOW_BLOCK, 1'b1, '0, '0, '0, '0, '0),
			1, RS_ZERO);
		add_row(req_of(FN_QUEUE, 7'd64, SET_BYTES, HOW_BLOCK, 1'b1, '0, '0, '0, '0, '0),
			1, RS_ZERO);
		// top signal, default action: terminate with the largest exit code
		add_row(req_of(FN_DELIVER, 7'd0, '0, HOW_BLOCK, 1'b0, '0, '0, '0, '0, '0),
			1, rsp_of(ST_OK, OC_TERM, 7'd64, 8'd192, '0, '0, '0, '0));
		// kill and stop refuse an action, as does a bad size
		add_row(req_of(FN_SETACT, SIG_KILL, SET_BYTES, HOW_BLOCK, 1'b1, '0, A5, A5, 3'd7, ONES),
			1, rsp_of(ST_INVAL, OC_NONE, '0, '0, '0, '0, '0, '0));
		add_row(req_of(FN_SETACT, SIG_STOP, SET_BYTES, HOW_BLOCK, 1'b1, '0, A5, A5, 3'd7, ONES),
			1, rsp_of(ST_INVAL, OC_NONE, '0, '0, '0, '0, '0, '0));
		add_row(req_of(FN_SETACT, 7'd1, 8'd0, HOW_BLOCK, 1'b1, '0, A5, A5, 3'd7, ONES),
			1, rsp_of(ST_INVAL, OC_NONE, '0, '0, '0, '0, '0, '0));
		add_row(req_of(FN_SETACT, 7'd1, SET_BYTES, HOW_BLOCK, 1'b1, '0, ONES, A5, 3'd7, ONES),
			1, RS_ZERO);
		// read back the action just installed
		add_row(req_of(FN_SETACT, 7'd1, SET_BYTES, HOW_BLOCK, 1'b0, '0, '0, '0, '0, '0),
			1, rsp_of(ST_OK, OC_NONE, '0, '0, ONES, A5, 3'd7, ONES));
		add_row(req_of(FN_PROCMASK, 7'd0, SET_BYTES, HOW_SET, 1'b1, ONES, '0, '0, '0, '0),
			1, RS_ZERO);
		// full mask comes back without kill and stop
		add_row(req_of(FN_PROCMASK, 7'd0, SET_BYTES, HOW_SET, 1'b0, '0, '0, '0, '0, '0),
			1, rsp_of(ST_OK, OC_NONE, '0, '0, '0, '0, '0, ~UNMASKABLE));
		add_row(req_of(FN_PROCMASK, 7'd0, 8'd255, HOW_BLOCK, 1'b1, '0, '0, '0, '0, '0),
			1, rsp_of(ST_INVAL, OC_NONE, '0, '0, '0, '0, '0, '0));
		add_row(req_of(FN_QUEUE, SIG_KILL, SET_BYTES, HOW_BLOCK, 1'b1, '0, '0, '0, '0, '0),
			1, RS_ZERO);
		add_row(req_of(FN_QUEUE, 7'd1, SET_BYTES, HOW_BLOCK, 1'b1, '0, '0, '0, '0, '0),
			1, RS_ZERO);
		// everything blocked but kill gets through
		add_row(req_of(FN_DELIVER, 7'd0, '0, HOW_BLOCK, 1'b0, '0, '0, '0, '0, '0),
			1, rsp_of(ST_OK, OC_TERM, SIG_KILL, 8'd137, '0, '0, '0, '0));
		add_row(req_of(FN_RETURN, 7'd0, '0, HOW_BLOCK, 1'b0, '0, '0, '0, '0, '0), 1, RS_ZERO);
		// handler with no-defer and reset-handler flags
		add_row(req_of(FN_DELIVER, 7'd0, '0, HOW_BLOCK, 1'b0, '0, '0, '0, '0, '0), 0, RS_ZERO);
		add_row(req_of(FN_SUSPEND, 7'd0, SET_BYTES, HOW_BLOCK, 1'b1, ONES, '0, '0, '0, '0),
			0, RS_ZERO);
		add_row(req_of(FN_RETURN, 7'd0, '0, HOW_BLOCK, 1'b1, '0, '0, '0, '0, '0), 1, RS_ZERO);
		add_row(req_of(FN_QUEUE, 7'd17, SET_BYTES, HOW_BLOCK, 1'b1, '0, '0, '0, '0, '0),
			1, RS_ZERO);
		// default action that is ignored
		add_row(req_of(FN_DELIVER, 7'd0, '0, HOW_BLOCK, 1'b0, '0, '0, '0, '0, '0),
			1, rsp_of(ST_OK, OC_DISCARD, 7'd17, '0, '0, '0, '0, '0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) put_txn(dir_rows[i].q, dir_rows[i].typed, dir_rows[i].want);

		n_total = n_sent + N_RANDOM;
		while (n_sent < n_total) begin
			// Idling on both sides comes and goes; the tail of the run goes flat out.
			src_idle_on  = (n_sent < n_total - 120) && ($urandom_range(0, 3) != 0);
			snk_stall_on = (n_sent < n_total - 120) && ($urandom_range(0, 3) != 0);
			if (n_sent >= next_drain) begin
				drain_owed();
				next_drain = n_sent + 250;
			end
			if ($urandom_range(0, 4) < 2) begin
				put_txn(noise_req(), 0, RS_ZERO);
			end else begin
				// Typical handler round trip: install, raise, suspend, deliver, return, read pending.
				s  = $urandom_range(1, 64);
				nh = ($urandom_range(0, 5) == 0) ? HANDLER_IGN : ({$urandom, $urandom} | 64'h100);
				put_txn(req_of(FN_SETACT, 7'(s), SET_BYTES, HOW_BLOCK, 1'b1, '0, nh,
					{$urandom, $urandom}, 3'($urandom_range(0, 7)), any_mask()), 0, RS_ZERO);
				put_txn(req_of(FN_QUEUE, 7'(s), SET_BYTES, HOW_BLOCK, 1'b1, '0, '0, '0, '0, '0),
					0, RS_ZERO);
				if ($urandom_range(0, 1) == 0)
					put_txn(req_of(FN_QUEUE, 7'($urandom_range(1, 64)), SET_BYTES, HOW_BLOCK,
						1'b1, '0, '0, '0, '0, '0), 0, RS_ZERO);
				if ($urandom_range(0, 1) == 0)
					put_txn(req_of(FN_PROCMASK, 7'(s), SET_BYTES, 2'($urandom_range(0, 2)),
						1'b1, any_mask(), '0, '0, '0, '0), 0, RS_ZERO);
				put_txn(req_of(FN_SUSPEND, 7'(s), SET_BYTES, HOW_BLOCK, 1'b1,
					any_mask() & ~(64'd1 << (s - 1)), '0, '0, '0, '0), 0, RS_ZERO);
				put_txn(req_of(FN_DELIVER, 7'(s), SET_BYTES, HOW_BLOCK, 1'b1, '0, '0, '0, '0, '0),
					0, RS_ZERO);
				if ($urandom_range(0, 1) == 0)
					put_txn(req_of(FN_DELIVER, 7'(s), SET_BYTES, HOW_BLOCK, 1'b1, '0, '0, '0,
						'0, '0), 0, RS_ZERO);
				put_txn(req_of(FN_RETURN, 7'(s), SET_BYTES, HOW_BLOCK, 1'($urandom_range(0, 1)),
					any_mask(), '0, '0, '0, '0), 0, RS_ZERO);
				put_txn(req_of(FN_READPEND, 7'(s), SET_BYTES, HOW_BLOCK, 1'b1, '0, '0, '0, '0,
					'0), 0, RS_ZERO);
			end
		end

		// Let the last responses drain, then watch for strays.
		drain_owed();
		repeat (10) @(posedge clk);
		if (n_bad == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
